@@ design/radial_gradient_disc_shader_assert.svh @@
// Assertion macros for the radial gradient disc shader checker.
// Depends on signals named clk and rst_n in the scope that uses them.
`ifndef RADIAL_GRADIENT_DISC_SHADER_ASSERT_SVH
`define RADIAL_GRADIENT_DISC_SHADER_ASSERT_SVH

// Clocked implication, disabled during reset
`define RGDS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Clocked next-cycle implication, disabled during reset
`define RGDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rgds_pkg.sv @@
// Shared types and constants of the radial gradient disc shader.
// No dependencies.
package rgds_pkg;

    localparam int COORD_W  = 11;
    localparam int IDX_W    = 8;
    localparam int COLOR_W  = 32;
    localparam int RAD_W    = 11;
    localparam int D2_W     = 22;
    localparam int SCALE_W  = 16;
    localparam int PROD_W   = 38;
    localparam int ROOT_W   = 19;
    localparam int CFG_W    = 2;

    localparam logic [SCALE_W-1:0] SCALE_SQ = 16'd65025;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_SHADE = 1'b1;

    localparam logic [CFG_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_W-1:0] CFG_RADIUS   = 2'd2;

    // Item fields that travel alongside the arithmetic
    typedef struct packed {
        logic               valid;
        logic               func;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [IDX_W-1:0]   slot;
        logic [COLOR_W-1:0] color;
    } sband_t;

endpackage

@@ design/rgds_in_if.sv @@
// Input channel of the radial gradient disc shader.
// Depends on rgds_pkg.
interface rgds_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [rgds_pkg::COORD_W-1:0]  pixel_x;
    logic [rgds_pkg::COORD_W-1:0]  pixel_y;
    logic [rgds_pkg::IDX_W-1:0]    entry_index;
    logic [rgds_pkg::COLOR_W-1:0]  entry_color;

    modport source (output valid, func, pixel_x, pixel_y, entry_index, entry_color,
                    input ready);
    modport sink (input valid, func, pixel_x, pixel_y, entry_index, entry_color,
                  output ready);
endinterface

@@ design/rgds_out_if.sv @@
// Output channel of the radial gradient disc shader.
// Depends on rgds_pkg.
interface rgds_out_if;
    logic                          valid;
    logic                          ready;
    logic [rgds_pkg::COORD_W-1:0]  out_x;
    logic [rgds_pkg::COORD_W-1:0]  out_y;
    logic [rgds_pkg::IDX_W-1:0]    shade_index;
    logic [rgds_pkg::COLOR_W-1:0]  pixel_color;

    modport source (output valid, out_x, out_y, shade_index, pixel_color, input ready);
    modport sink (input valid, out_x, out_y, shade_index, pixel_color, output ready);
endinterface

@@ design/rgds_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on rgds_pkg.
module rgds_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  rgds_pkg::sband_t              sb_in,
    input  logic [rgds_pkg::PROD_W-1:0]   opnd,
    output rgds_pkg::sband_t              sb_out,
    output logic [rgds_pkg::ROOT_W-1:0]   root
);

    localparam int RW = rgds_pkg::ROOT_W;
    localparam int MW = rgds_pkg::PROD_W;

    typedef struct packed {
        logic [RW+1:0] rem;
        logic [RW-1:0] root;
        logic [MW-1:0] opnd;
    } sq_t;

    sq_t              st_reg [RW];
    sq_t              st_next [RW];
    rgds_pkg::sband_t sb_reg [RW];

    // One digit: bring down two operand bits and try the next root bit
    function automatic sq_t sq_step(sq_t s);
        logic [RW+1:0] rem_sh;
        logic [RW+1:0] trial;
        sq_t           r;
        rem_sh = {s.rem[RW-1:0], s.opnd[MW-1:MW-2]};
        trial  = {s.root, 2'b01};
        r.opnd = {s.opnd[MW-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            r.rem  = rem_sh - trial;
            r.root = {s.root[RW-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_sh;
            r.root = {s.root[RW-2:0], 1'b0};
        end
        return r;
    endfunction

    // Compute each stage from the one before it
    always_comb
    begin
        st_next[0] = sq_step('{rem: '0, root: '0, opnd: opnd});
        for (int i = 1; i < RW; i++)
        begin
            st_next[i] = sq_step(st_reg[i-1]);
        end
    end

    // Advance all stages together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RW; i++)
            begin
                sb_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            sb_reg[0] <= sb_in;
            for (int i = 1; i < RW; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < RW; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign sb_out = sb_reg[RW-1];
    assign root   = st_reg[RW-1].root;

endmodule

@@ design/rgds_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rgds_pkg.
module rgds_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  rgds_pkg::sband_t              sb_in,
    input  logic [rgds_pkg::ROOT_W-1:0]   dividend,
    input  logic [rgds_pkg::RAD_W-1:0]    divisor,
    output rgds_pkg::sband_t              sb_out,
    output logic [rgds_pkg::IDX_W-1:0]    quotient
);

    localparam int RW = rgds_pkg::ROOT_W;
    localparam int QW = rgds_pkg::IDX_W;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QW-1:0] q;
    } dv_t;

    dv_t              st_reg [QW];
    dv_t              st_next [QW];
    rgds_pkg::sband_t sb_reg [QW];

    // Try one quotient bit against the shifted divisor
    function automatic dv_t dv_step(dv_t s, logic [RW-1:0] d, int b);
        logic [RW-1:0] dsh;
        dv_t           r;
        dsh = d << b;
        r   = s;
        if (s.rem >= dsh)
        begin
            r.rem  = s.rem - dsh;
            r.q[b] = 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        st_next[0] = dv_step('{rem: dividend, q: '0}, RW'(divisor), QW - 1);
        for (int i = 1; i < QW; i++)
        begin
            st_next[i] = dv_step(st_reg[i-1], RW'(divisor), QW - 1 - i);
        end
    end

    // Advance all stages together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QW; i++)
            begin
                sb_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            sb_reg[0] <= sb_in;
            for (int i = 1; i < QW; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QW; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign sb_out   = sb_reg[QW-1];
    assign quotient = st_reg[QW-1].q;

endmodule

@@ design/rgds_palette.sv @@
// Palette memory: one port, a load beat writes, a shade beat reads.
// Depends on rgds_pkg.
module rgds_palette #(
    parameter int ENTRIES = 256
) (
    input  logic                          clk,
    input  logic                          en,
    input  rgds_pkg::sband_t              sb,
    input  logic [rgds_pkg::IDX_W-1:0]    shade_idx,
    output logic [rgds_pkg::COLOR_W-1:0]  rdata
);

    localparam int AW = $clog2(ENTRIES);

    logic [rgds_pkg::COLOR_W-1:0] mem [ENTRIES];
    logic [AW-1:0]                waddr;
    logic [AW-1:0]                raddr;
    logic                         slot_ok;

    // Wrap an index into the palette by compare and subtract per bit
    function automatic logic [AW-1:0] wrap_idx(logic [rgds_pkg::IDX_W-1:0] v);
        logic [31:0] rem;
        rem = 32'(v);
        for (int k = rgds_pkg::IDX_W - 1; k >= 0; k--)
        begin
            if (rem >= (32'(ENTRIES) << k))
            begin
                rem = rem - (32'(ENTRIES) << k);
            end
        end
        return AW'(rem);
    endfunction

    assign slot_ok = 32'(sb.slot) < ENTRIES;
    assign waddr   = AW'(32'(sb.slot));
    assign raddr   = wrap_idx(shade_idx);

    // Serve loads and reads in beat order; read data holds under stall
    always_ff @(posedge clk)
    begin
        if (en && sb.valid)
        begin
            if (sb.func == rgds_pkg::FUNC_LOAD)
            begin
                if (slot_ok)
                begin
                    mem[waddr] <= sb.color;
                end
            end
            else
            begin
                rdata <= mem[raddr];
            end
        end
    end

endmodule

@@ design/radial_gradient_disc_shader.sv @@
// Top level of the radial gradient disc shader.
// Depends on rgds_pkg, rgds_in_if, rgds_out_if, rgds_sqrt, rgds_div, rgds_palette.
//
// Usage:
//   in_ch carries one beat per item: func 0 loads entry_color into palette
//   slot entry_index, func 1 presents pixel (pixel_x, pixel_y). out_ch
//   carries a beat for each pixel strictly inside the disc, with the
//   palette colour at floor(255 * distance / radius). Loads and pixels
//   outside the disc give no output beat.
//   cfg_we / cfg_index / cfg_wdata write center_x, center_y, disc_radius;
//   write them only while the pipeline is empty.
//   Throughput: one item per cycle unless out_ch stalls. An input beat
//   passes the distance arithmetic, 19 square-root stages, 8 divider
//   stages, then the palette read into the output register.
//   Palette loads travel down the same pipeline and write the memory at
//   the stage where pixels read it, so order between loads and reads holds.
//   Reset empties the pipeline and clears the configuration registers;
//   palette contents are undefined until loaded. When out_ch stalls, the
//   whole pipeline holds and in_ch.ready drops in the same cycle.
module radial_gradient_disc_shader #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int COORD_BITS      = 11
) (
    input  logic                         clk,
    input  logic                         rst_n,
    rgds_in_if.sink                      in_ch,
    rgds_out_if.source                   out_ch,
    input  logic                         cfg_we,
    input  logic [rgds_pkg::CFG_W-1:0]   cfg_index,
    input  logic [rgds_pkg::RAD_W-1:0]   cfg_wdata
);

    localparam int CW = rgds_pkg::COORD_W;
    localparam int DW = rgds_pkg::D2_W;
    localparam logic [CW-1:0] CMASK =
        (COORD_BITS >= CW) ? '1 : CW'((32'd1 << COORD_BITS) - 32'd1);

    logic [CW-1:0]                center_x_reg;
    logic [CW-1:0]                center_y_reg;
    logic [rgds_pkg::RAD_W-1:0]   radius_reg;
    logic [DW-1:0]                r2_reg;

    logic                         adv;
    logic [CW-1:0]                px_m;
    logic [CW-1:0]                py_m;
    logic [CW-1:0]                cx_m;
    logic [CW-1:0]                cy_m;

    rgds_pkg::sband_t             a_sb_reg, b_sb_reg, c_sb_reg, d_sb_reg;
    rgds_pkg::sband_t             a_sb_next, c_sb_next;
    logic [CW-1:0]                a_dx_reg, a_dy_reg;
    logic [DW-1:0]                b_dx2_reg, b_dy2_reg;
    logic [DW-1:0]                c_d2_reg;
    logic [rgds_pkg::PROD_W-1:0]  d_prod_reg;
    logic [DW:0]                  d2_sum;
    logic                         in_disc;

    rgds_pkg::sband_t             sq_sb, dv_sb;
    logic [rgds_pkg::ROOT_W-1:0]  sq_root;
    logic [rgds_pkg::IDX_W-1:0]   dv_q;

    logic                         out_valid_reg;
    logic [CW-1:0]                out_x_reg, out_y_reg;
    logic [rgds_pkg::IDX_W-1:0]   out_idx_reg;
    logic [rgds_pkg::COLOR_W-1:0] pal_rdata;

    // Advance whenever the output register is free or being drained
    assign adv         = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // Hold configuration; keep radius squared ready for the disc test
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
            r2_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rgds_pkg::CFG_CENTER_X: center_x_reg <= cfg_wdata;
                rgds_pkg::CFG_CENTER_Y: center_y_reg <= cfg_wdata;
                rgds_pkg::CFG_RADIUS:
                begin
                    radius_reg <= cfg_wdata;
                    r2_reg     <= DW'(cfg_wdata) * DW'(cfg_wdata);
                end
                default: ;
            endcase
        end
    end

    // Mask coordinates and take absolute differences
    assign px_m = in_ch.pixel_x & CMASK;
    assign py_m = in_ch.pixel_y & CMASK;
    assign cx_m = center_x_reg & CMASK;
    assign cy_m = center_y_reg & CMASK;

    always_comb
    begin
        a_sb_next.valid = in_ch.valid;
        a_sb_next.func  = in_ch.func;
        a_sb_next.x     = px_m;
        a_sb_next.y     = py_m;
        a_sb_next.slot  = in_ch.entry_index;
        a_sb_next.color = in_ch.entry_color;
    end

    // Disc test: drop pixels outside, keep loads
    assign d2_sum  = {1'b0, b_dx2_reg} + {1'b0, b_dy2_reg};
    assign in_disc = (radius_reg != '0) && (d2_sum < {1'b0, r2_reg});

    always_comb
    begin
        c_sb_next       = b_sb_reg;
        c_sb_next.valid = b_sb_reg.valid &&
                          ((b_sb_reg.func == rgds_pkg::FUNC_LOAD) || in_disc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_sb_reg <= '0;
            b_sb_reg <= '0;
            c_sb_reg <= '0;
            d_sb_reg <= '0;
        end
        else if (adv)
        begin
            a_sb_reg <= a_sb_next;
            b_sb_reg <= a_sb_reg;
            c_sb_reg <= c_sb_next;
            d_sb_reg <= c_sb_reg;
        end
    end

    // Distance arithmetic: differences, squares, sum, scale by 255 squared
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_dx_reg   <= (px_m > cx_m) ? px_m - cx_m : cx_m - px_m;
            a_dy_reg   <= (py_m > cy_m) ? py_m - cy_m : cy_m - py_m;
            b_dx2_reg  <= DW'(a_dx_reg) * DW'(a_dx_reg);
            b_dy2_reg  <= DW'(a_dy_reg) * DW'(a_dy_reg);
            c_d2_reg   <= d2_sum[DW-1:0];
            d_prod_reg <= rgds_pkg::PROD_W'(c_d2_reg) * rgds_pkg::PROD_W'(rgds_pkg::SCALE_SQ);
        end
    end

    rgds_sqrt u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .sb_in  (d_sb_reg),
        .opnd   (d_prod_reg),
        .sb_out (sq_sb),
        .root   (sq_root)
    );

    rgds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .sb_in    (sq_sb),
        .dividend (sq_root),
        .divisor  (radius_reg),
        .sb_out   (dv_sb),
        .quotient (dv_q)
    );

    rgds_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk       (clk),
        .en        (adv),
        .sb        (dv_sb),
        .shade_idx (dv_q),
        .rdata     (pal_rdata)
    );

    // Output register alongside the palette read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_sb.valid && (dv_sb.func == rgds_pkg::FUNC_SHADE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg   <= dv_sb.x;
            out_y_reg   <= dv_sb.y;
            out_idx_reg <= dv_q;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_x       = out_x_reg;
    assign out_ch.out_y       = out_y_reg;
    assign out_ch.shade_index = out_idx_reg;
    assign out_ch.pixel_color = pal_rdata;

endmodule

@@ design/rgds_checker.sv @@
// Port-level checker for the radial gradient disc shader, with its bind.
// Depends on radial_gradient_disc_shader_assert.svh and the top level.
`include "radial_gradient_disc_shader_assert.svh"

module rgds_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] shade_index
);

    // A stalled output beat stays offered
    `RGDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output beat dropped under stall")

    // Input is taken whenever the output side can move
    `RGDS_ASSERT_IMP(a_in_ready, !out_valid || out_ready, in_ready, "input stalled while output free")

    // Shade index never reaches 255
    `RGDS_ASSERT_IMP(a_idx_range, out_valid, shade_index != 8'hFF, "shade index out of range")

endmodule

bind radial_gradient_disc_shader rgds_checker u_rgds_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .shade_index (out_ch.shade_index)
);
